FILE: rtl/core/utf8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
// Used by utf8v_step and utf8_stream_validator_core; depends on nothing.
`default_nettype none

package utf8v_pkg;

   // control_policy register codes
   localparam logic [1:0] POLICY_NONE    = 2'd0;
   localparam logic [1:0] POLICY_TEXT    = 2'd1;
   localparam logic [1:0] POLICY_LANGTAG = 2'd2;

   localparam int CODE_W = 21;

   localparam logic [CODE_W-1:0] CODE_MAX       = 21'h10FFFF;
   localparam logic [CODE_W-1:0] SURROGATE_LO   = 21'h00D800;
   localparam logic [CODE_W-1:0] SURROGATE_HI   = 21'h00DFFF;
   localparam logic [CODE_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [CODE_W-1:0] MIN_FOUR_BYTE  = 21'h010000;

   localparam logic [7:0] BYTE_NUL = 8'h00;
   localparam logic [7:0] BYTE_TAB = 8'h09;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_SP  = 8'h20;
   localparam logic [7:0] BYTE_DEL = 8'h7F;

   // per-string decode state
   typedef struct packed {
      logic [1:0]        bytes_pending;
      logic [2:0]        sequence_length;
      logic [CODE_W-1:0] code_accumulator;
      logic              error_seen;
   } string_state_type;

   localparam string_state_type STATE_CLEAR = '0;

endpackage

`default_nettype wire

FILE: rtl/core/utf8v_step.sv
// Per-byte next-state logic of the UTF-8 validator: decode, range and control checks.
// Depends on utf8v_pkg.
`default_nettype none

module utf8v_step (
   input  utf8v_pkg::string_state_type cur_state,
   input  logic [7:0]                  data_byte,
   input  logic [1:0]                  control_policy,
   output utf8v_pkg::string_state_type nxt_state,
   output logic                        string_valid
);
   import utf8v_pkg::*;

   logic              ctrl_bad;
   logic [CODE_W-1:0] cont_code;
   logic              cp_bad;

   always_comb begin
      case (control_policy)
         POLICY_TEXT: begin
            ctrl_bad = (data_byte < BYTE_SP && data_byte != BYTE_LF && data_byte != BYTE_TAB)
                       || data_byte == BYTE_DEL;
         end
         POLICY_LANGTAG: begin
            ctrl_bad = data_byte <= BYTE_SP || data_byte == BYTE_DEL;
         end
         default: begin
            ctrl_bad = 1'b0;
         end
      endcase
   end

   assign cont_code = {cur_state.code_accumulator[CODE_W-7:0], data_byte[5:0]};

   assign cp_bad = (cur_state.sequence_length == 3'd3 && cont_code < MIN_THREE_BYTE) ||
                   (cur_state.sequence_length == 3'd4 && cont_code < MIN_FOUR_BYTE) ||
                   (cont_code >= SURROGATE_LO && cont_code <= SURROGATE_HI) ||
                   cont_code > CODE_MAX;

   always_comb begin
      nxt_state = cur_state;
      if (ctrl_bad) begin
         nxt_state.error_seen = 1'b1;
      end
      // once an error is seen, absorb the rest of the string
      if (!(cur_state.error_seen || ctrl_bad)) begin
         if (cur_state.bytes_pending != 2'd0) begin
            if (data_byte[7:6] != 2'b10) begin
               nxt_state.error_seen = 1'b1;
            end else begin
               nxt_state.code_accumulator = cont_code;
               nxt_state.bytes_pending    = cur_state.bytes_pending - 2'd1;
               if (cur_state.bytes_pending == 2'd1 && cp_bad) begin
                  nxt_state.error_seen = 1'b1;
               end
            end
         end else if (data_byte == BYTE_NUL) begin
            nxt_state.error_seen = 1'b1;
         end else if (data_byte[7] == 1'b0) begin
            nxt_state.sequence_length  = 3'd1;
            nxt_state.code_accumulator = {{(CODE_W-8){1'b0}}, data_byte};
         end else if (data_byte[7:5] == 3'b110) begin
            if (data_byte[4:0] < 5'd2) begin
               nxt_state.error_seen = 1'b1;
            end else begin
               nxt_state.sequence_length  = 3'd2;
               nxt_state.code_accumulator = {{(CODE_W-5){1'b0}}, data_byte[4:0]};
               nxt_state.bytes_pending    = 2'd1;
            end
         end else if (data_byte[7:4] == 4'b1110) begin
            nxt_state.sequence_length  = 3'd3;
            nxt_state.code_accumulator = {{(CODE_W-4){1'b0}}, data_byte[3:0]};
            nxt_state.bytes_pending    = 2'd2;
         end else if (data_byte[7:3] == 5'b11110) begin
            nxt_state.sequence_length  = 3'd4;
            nxt_state.code_accumulator = {{(CODE_W-3){1'b0}}, data_byte[2:0]};
            nxt_state.bytes_pending    = 2'd3;
         end else begin
            // stray continuation or bad lead
            nxt_state.error_seen = 1'b1;
         end
      end
   end

   assign string_valid = !nxt_state.error_seen && nxt_state.bytes_pending == 2'd0;

endmodule

`default_nettype wire

FILE: rtl/core/utf8_stream_validator_core.sv
// Top level of the UTF-8 stream validator: input register, state, result register.
// Depends on utf8v_pkg and utf8v_step.
`default_nettype none

// Takes one byte per cycle with a last-byte flag, unless req_stall holds it, and
// reports, one transaction per string, whether the string is well-formed UTF-8
// free of NUL and of the control bytes that csr_control_policy rejects. Sustained
// rate is one byte per clock while results are not stalled; the single decode step
// between the input register and the string state sets that figure. Results are
// registered. Write the policy only while no string is in flight.
module utf8_stream_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_string_valid,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_control_policy
);
   import utf8v_pkg::*;

   logic             in_vld_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic [1:0]       policy_ff;
   string_state_type state_ff, state_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic             rsp_ok_ff;
   string_state_type step_state;
   logic             step_valid;
   logic             advance;
   logic             take;

   utf8v_step u_step (
      .cur_state      (state_ff),
      .data_byte      (in_byte_ff),
      .control_policy (policy_ff),
      .nxt_state      (step_state),
      .string_valid   (step_valid)
   );

   // a non-last byte never waits on the result side
   assign advance   = in_vld_ff && (!in_last_ff || !rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = in_last_ff ? STATE_CLEAR : step_state;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      if (advance && in_last_ff) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= STATE_CLEAR;
         policy_ff  <= POLICY_NONE;
      end else begin
         if (take || advance) begin
            in_vld_ff <= take;
         end
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_control_policy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_ok_ff <= step_valid;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_string_valid = rsp_ok_ff;

   // string state is cleared once the last byte has gone through
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == STATE_CLEAR && rsp_vld_ff)
      else $error("string state not cleared after last byte");

   a_pending_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_pending != 2'd0 |->
         {1'b0, state_ff.bytes_pending} < state_ff.sequence_length)
      else $error("pending count exceeds sequence length");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && in_last_ff && rsp_vld_ff)
      else $error("input stalled without a waiting result");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |=> $stable(state_ff))
      else $error("string state changed with no byte in flight");

endmodule

`default_nettype wire
